// ----- rtl/apsp_pkg.sv -----
// Shared types, constants and helpers for the all-pairs shortest path block.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package apsp_pkg;

  // Graph size and derived widths.
  localparam int VERTICES = 16;
  localparam int VIDX_W   = $clog2(VERTICES);
  localparam int ADDR_W   = 2 * VIDX_W;
  localparam int CELLS    = 1 << ADDR_W;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 20;

  typedef logic [VIDX_W-1:0]   vidx_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [DIST_W-1:0]   dist_t;

  localparam vidx_t VMAX     = VIDX_W'(VERTICES - 1);
  localparam dist_t DIST_INF = '1;

  // Item opcodes.
  localparam logic OPC_SET   = 1'b0;
  localparam logic OPC_QUERY = 1'b1;

  // Controller to datapath command codes.
  localparam int CMD_W = 4;
  localparam logic [CMD_W-1:0] CMD_NONE  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_WR_AB = 4'd2;
  localparam logic [CMD_W-1:0] CMD_WR_BA = 4'd3;
  localparam logic [CMD_W-1:0] CMD_COPY  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_ROW   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_RELAX = 4'd6;
  localparam logic [CMD_W-1:0] CMD_QUERY = 4'd7;
  localparam logic [CMD_W-1:0] CMD_MISS  = 4'd8;

  // Input beat.
  typedef struct packed {
    logic        opcode;
    logic [3:0]  vertex_a;
    logic [3:0]  vertex_b;
    weight_t     weight;
  } item_t;

  // Result beat.
  typedef struct packed {
    dist_t distance;
    logic  reachable;
  } result_t;

  // Command from controller to datapath.
  typedef struct packed {
    logic [CMD_W-1:0] op;
    vidx_t            i;
    vidx_t            j;
    vidx_t            k;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic opcode;
    logic in_range;
  } stat_t;

  // Row-major matrix address.
  function automatic addr_t cell_addr(input vidx_t row, input vidx_t col);
    cell_addr = {row, col};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/apsp_ctrl.sv -----
// Sequencing state machine: decodes items, runs the copy, row-load and
// relaxation sweeps of Floyd-Warshall, and tracks whether cached distances hold.
// Depends on apsp_pkg.
`default_nettype none

module apsp_ctrl
  import apsp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire stat_t stat,
  output logic       busy,
  output cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_WR_BA  = 3'd2;
  localparam logic [2:0] ST_COPY   = 3'd3;
  localparam logic [2:0] ST_ROWLD  = 3'd4;
  localparam logic [2:0] ST_RELAX  = 3'd5;
  localparam logic [2:0] ST_QRY    = 3'd6;
  localparam logic [2:0] ST_RESP   = 3'd7;

  logic [2:0] state, state_next;
  vidx_t      i, i_next;
  vidx_t      j, j_next;
  vidx_t      k, k_next;
  logic       current, current_next;

  // Next state, loop counters and the command for this cycle.
  always_comb begin
    state_next   = state;
    i_next       = i;
    j_next       = j;
    k_next       = k;
    current_next = current;
    cmd          = '{op: CMD_NONE, i: i, j: j, k: k};
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.op     = CMD_LOAD;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.opcode == OPC_SET) begin
          if (stat.in_range) begin
            cmd.op       = CMD_WR_AB;
            current_next = 1'b0;
            state_next   = ST_WR_BA;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (!stat.in_range) begin
          cmd.op     = CMD_MISS;
          state_next = ST_RESP;
        end else if (current) begin
          cmd.op     = CMD_QUERY;
          state_next = ST_RESP;
        end else begin
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          state_next = ST_COPY;
        end
      end
      ST_WR_BA: begin
        cmd.op     = CMD_WR_BA;
        state_next = ST_IDLE;
      end
      ST_COPY: begin
        cmd.op = CMD_COPY;
        j_next = j + 1'b1;
        if (j == VMAX) begin
          j_next = '0;
          i_next = i + 1'b1;
          if (i == VMAX) begin
            i_next     = '0;
            state_next = ST_ROWLD;
          end
        end
      end
      ST_ROWLD: begin
        cmd.op = CMD_ROW;
        j_next = j + 1'b1;
        if (j == VMAX) begin
          j_next     = '0;
          state_next = ST_RELAX;
        end
      end
      ST_RELAX: begin
        cmd.op = CMD_RELAX;
        j_next = j + 1'b1;
        if (j == VMAX) begin
          j_next = '0;
          i_next = i + 1'b1;
          if (i == VMAX) begin
            i_next = '0;
            if (k == VMAX) begin
              current_next = 1'b1;
              state_next   = ST_QRY;
            end else begin
              k_next     = k + 1'b1;
              state_next = ST_ROWLD;
            end
          end
        end
      end
      ST_QRY: begin
        cmd.op     = CMD_QUERY;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      i       <= '0;
      j       <= '0;
      k       <= '0;
      current <= 1'b0;
    end else begin
      state   <= state_next;
      i       <= i_next;
      j       <= j_next;
      k       <= k_next;
      current <= current_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/apsp_datapath.sv -----
// Datapath: weight memory with valid bits, distance memory with two read
// ports, pivot row registers, saturating relaxation unit and result register.
// Depends on apsp_pkg.
`default_nettype none

module apsp_datapath
  import apsp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t item,
  input  wire cmd_t  cmd,
  output stat_t      stat,
  output logic       done,
  output result_t    result
);

  item_t            item_q;
  vidx_t            a_idx, b_idx;
  logic [WEIGHT_W-1:0] wmem [CELLS];
  logic [CELLS-1:0] wvalid;
  weight_t          wrd_q;
  logic             wvld_q;
  logic             wr_en;
  addr_t            wr_addr;
  addr_t            w_raddr;
  dist_t            dmem [CELLS];
  dist_t            rd_a_q, rd_b_q;
  addr_t            addr_a, addr_b;
  dist_t            row [VERTICES];
  logic [CMD_W-1:0] s1_op;
  vidx_t            s1_i, s1_j;
  logic [DIST_W:0]  via_sum;
  dist_t            via;
  dist_t            init_d;
  logic             dwr_en;
  addr_t            dwr_addr;
  dist_t            dwr_data;

  // Latch the accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LOAD) begin
      item_q <= item;
    end
  end

  assign a_idx = vidx_t'(item_q.vertex_a);
  assign b_idx = vidx_t'(item_q.vertex_b);

  // Status for the decode step.
  always_comb begin
    stat.opcode   = item_q.opcode;
    stat.in_range = (32'(item_q.vertex_a) < VERTICES) && (32'(item_q.vertex_b) < VERTICES);
  end

  // Weight memory: symmetric writes, a-to-b then b-to-a, one read for the copy sweep.
  assign wr_en   = (cmd.op == CMD_WR_AB) || (cmd.op == CMD_WR_BA);
  assign wr_addr = (cmd.op == CMD_WR_AB) ? cell_addr(a_idx, b_idx) : cell_addr(b_idx, a_idx);
  assign w_raddr = cell_addr(cmd.i, cmd.j);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wmem[wr_addr] <= item_q.weight;
    end
    wrd_q <= wmem[w_raddr];
  end

  // Valid bits stand in for clearing the weight memory at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
    end else if (wr_en) begin
      wvalid[wr_addr] <= 1'b1;
    end
    wvld_q <= wvalid[w_raddr];
  end

  // Distance memory read addresses.
  always_comb begin
    case (cmd.op)
      CMD_ROW:   addr_a = cell_addr(cmd.k, cmd.j);
      CMD_QUERY: addr_a = cell_addr(a_idx, b_idx);
      default:   addr_a = cell_addr(cmd.i, cmd.j);
    endcase
    addr_b = cell_addr(cmd.i, cmd.k);
  end

  // Stage one tracks the command whose read data is now registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_op <= CMD_NONE;
    end else begin
      s1_op <= cmd.op;
    end
    s1_i <= cmd.i;
    s1_j <= cmd.j;
  end

  // Saturating path through the pivot and the initial distance of a cell.
  always_comb begin
    via_sum = {1'b0, rd_b_q} + {1'b0, row[s1_j]};
    via     = (via_sum >= {1'b0, DIST_INF}) ? DIST_INF : via_sum[DIST_W-1:0];
    if (s1_i == s1_j) begin
      init_d = '0;
    end else if (!wvld_q || (wrd_q == '0)) begin
      init_d = DIST_INF;
    end else begin
      init_d = DIST_W'(wrd_q);
    end
  end

  // Distance memory write selection.
  always_comb begin
    dwr_addr = cell_addr(s1_i, s1_j);
    dwr_data = via;
    dwr_en   = 1'b0;
    case (s1_op)
      CMD_COPY: begin
        dwr_en   = 1'b1;
        dwr_data = init_d;
      end
      CMD_RELAX: begin
        dwr_en = (via < rd_a_q);
      end
      default: begin
        dwr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dwr_en) begin
      dmem[dwr_addr] <= dwr_data;
    end
    rd_a_q <= dmem[addr_a];
    rd_b_q <= dmem[addr_b];
  end

  // Pivot row, constant through one pivot pass.
  always_ff @(posedge clk) begin
    if (s1_op == CMD_ROW) begin
      row[s1_j] <= rd_a_q;
    end
  end

  // Result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (s1_op == CMD_QUERY) || (s1_op == CMD_MISS);
    end
    if (s1_op == CMD_QUERY) begin
      result <= '{distance: rd_a_q, reachable: (rd_a_q != DIST_INF)};
    end else if (s1_op == CMD_MISS) begin
      result <= '{distance: DIST_INF, reachable: 1'b0};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/all_pairs_shortest_path_top.sv -----
// All-pairs shortest path block: controller and datapath joined by command/status.
// An edge write gives no result. A query on a cached distance matrix returns its beat
// via the decode and response states; a query after a write runs the copy sweep over
// all VERTICES^2 cells and VERTICES pivot passes, each a row load of VERTICES cells
// and a relaxation over VERTICES^2 cells. One item at a time, busy high while
// working; results cannot be stalled. Synchronous reset empties the graph and cache.
`default_nettype none

module all_pairs_shortest_path_top
  import apsp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire item_t item,
  output logic       busy,
  output logic       done,
  output result_t    result
);

  cmd_t  cmd;
  stat_t stat;

  apsp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  apsp_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

`default_nettype wire

// ----- rtl/apsp_checker.sv -----
// Port-level checker for the all-pairs shortest path block, bound to the top.
// Depends on apsp_pkg.
`default_nettype none

module apsp_checker
  import apsp_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    done,
  input wire result_t result
);

  // An accepted beat always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // A result beat is shown only once the block is idle again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // A result beat lasts exactly one cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat repeated");

  // The reachable flag agrees with the distance.
  a_reach: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.reachable == (result.distance != DIST_INF)))
    else $error("reachable flag disagrees with distance");

endmodule

bind all_pairs_shortest_path_top apsp_checker u_apsp_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
